// ===== design/nfa_stream_matcher_assert.svh =====
// assertion macros for the nfa stream matcher
`ifndef NFA_STREAM_MATCHER_ASSERT_SVH
`define NFA_STREAM_MATCHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define NFASM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NFASM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NFASM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define NFASM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/nfasm_pkg.sv =====
// shared types, command codes and defaults of the nfa stream matcher
`timescale 1ns / 1ps
package nfasm_pkg;

    // parameter defaults
    localparam int NUM_STATES_DEF  = 32;
    localparam int SYMBOL_BITS_DEF = 8;
    localparam int TYPE_BITS_DEF   = 4;

    // stream field widths
    localparam int CMD_W       = 3;
    localparam int STATE_FLD_W = 5;
    localparam int SYM_FLD_W   = 8;
    localparam int TYPE_FLD_W  = 4;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_EPS    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_ACCEPT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FEED       = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_STEP,
        S_STEP_LAST,
        S_CLOS,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== design/nfa_stream_matcher.sv =====
// epsilon-nfa matcher: usage
// input stream: one transaction per command, tuser holds the command code,
//   tdata holds from_state, to_state, input_symbol and new_accept_type.
// output stream: one transaction per input transaction with match_type and
//   alive, describing the active set after that command.
// config: i_cfg_we writes the initial state; write it only while idle.
// after reset the edge memory is swept to zero, one row a cycle, over all
//   NUM_STATES << SYMBOL_BITS rows (8192 by default); no input is taken then.
// the block handles one command at a time; all work is on one state counter
//   that walks the NUM_STATES states (N below):
//   load commands: a scan of the N states (edge add first reads then writes its row)
//   start: closure passes over the N states until a pass adds nothing, then a scan
//   feed symbol: N edge-memory reads, then closure and scan
//   as for start
// the closure repeats passes over the epsilon table until nothing is added,
//   so at most N passes add states.
// the result sits in an output register; the next command is taken while it
//   waits, and a stalled receiver only holds the block once a second result is
//   ready to be placed.
`timescale 1ns / 1ps
`include "nfa_stream_matcher_assert.svh"
module nfa_stream_matcher
    import nfasm_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int TYPE_BITS   = TYPE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [STATE_FLD_W-1:0] i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // from_state [4:0], to_state [9:5], input_symbol [17:10],
    // new_accept_type [21:18], zero fill [23:22]
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,
    // command [2:0]
    input  logic [CMD_W-1:0]       i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // match_type [3:0], alive [4], zero fill [7:5]
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int SW        = $clog2(NUM_STATES);
    localparam int AW        = SW + SYMBOL_BITS;
    localparam int MEM_DEPTH = NUM_STATES << SYMBOL_BITS;

    // sequencer
    t_state r_state, n_state;
    logic [SW-1:0] r_cnt, n_cnt;
    logic          cnt_last;
    logic [AW-1:0] r_clr_addr;
    logic          clr_last;

    // configuration
    logic [STATE_FLD_W-1:0] r_initial_state;

    // automaton state
    logic [NUM_STATES-1:0] r_edge_mem [MEM_DEPTH];
    logic [NUM_STATES-1:0] r_eps [NUM_STATES];
    logic [TYPE_BITS-1:0]  r_acc [NUM_STATES];
    logic [NUM_STATES-1:0] r_active;
    logic [NUM_STATES-1:0] r_work;
    logic                  r_changed;
    logic [TYPE_BITS-1:0]  r_best;

    // latched item
    logic [SW-1:0]          r_from_idx;
    logic [SW-1:0]          r_to_idx;
    logic [SYMBOL_BITS-1:0] r_sym;
    logic [SW-1:0]          r_step_idx;

    // memory port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [NUM_STATES-1:0] mem_wdata;
    logic [NUM_STATES-1:0] r_rd_data;

    // output register
    logic                  r_out_valid;
    logic [TYPE_FLD_W-1:0] r_out_match;
    logic                  r_out_alive;
    logic                  out_load;

    // input field decode
    logic                        in_acc;
    logic [CMD_W-1:0]            in_cmd;
    logic [STATE_FLD_W-1:0]      in_from;
    logic [STATE_FLD_W-1:0]      in_to;
    logic [SYM_FLD_W-1:0]        in_sym;
    logic [TYPE_FLD_W-1:0]       in_atype;
    logic [SW+STATE_FLD_W-1:0]   from_wide;
    logic [SW+STATE_FLD_W-1:0]   to_wide;
    logic [SW+STATE_FLD_W-1:0]   init_wide;
    logic [SYMBOL_BITS+SYM_FLD_W-1:0] sym_wide;
    logic [TYPE_BITS+TYPE_FLD_W-1:0]  atype_wide;
    logic [TYPE_BITS+TYPE_FLD_W-1:0]  best_wide;
    logic [SW-1:0]          from_idx;
    logic [SW-1:0]          to_idx;
    logic [SW-1:0]          init_idx;
    logic [SYMBOL_BITS-1:0] sym_idx;
    logic [TYPE_BITS-1:0]   atype_val;
    logic                   from_ok;
    logic                   to_ok;
    logic                   init_ok;
    logic [NUM_STATES-1:0]  start_set;
    logic [NUM_STATES-1:0]  to_onehot;

    // closure and scan unit
    logic [NUM_STATES-1:0] clos_add;
    logic [NUM_STATES-1:0] work_next;
    logic                  clos_change;
    logic                  step_take;
    logic                  best_take;

    // field unpacking
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd   = i_s_axis_tuser;
    assign in_from  = i_s_axis_tdata[4:0];
    assign in_to    = i_s_axis_tdata[9:5];
    assign in_sym   = i_s_axis_tdata[17:10];
    assign in_atype = i_s_axis_tdata[21:18];

    // resize fields to the configured widths
    assign from_wide  = {SW'(0), in_from};
    assign to_wide    = {SW'(0), in_to};
    assign init_wide  = {SW'(0), r_initial_state};
    assign sym_wide   = {SYMBOL_BITS'(0), in_sym};
    assign atype_wide = {TYPE_BITS'(0), in_atype};
    assign from_idx   = from_wide[SW-1:0];
    assign to_idx     = to_wide[SW-1:0];
    assign init_idx   = init_wide[SW-1:0];
    assign sym_idx    = sym_wide[SYMBOL_BITS-1:0];
    assign atype_val  = atype_wide[TYPE_BITS-1:0];
    assign from_ok    = 32'(in_from) < 32'(NUM_STATES);
    assign to_ok      = 32'(in_to) < 32'(NUM_STATES);
    assign init_ok    = 32'(r_initial_state) < 32'(NUM_STATES);
    assign start_set  = init_ok ? (NUM_STATES'(1) << init_idx) : '0;
    assign to_onehot  = NUM_STATES'(1) << r_to_idx;

    assign cnt_last = (r_cnt == SW'(NUM_STATES - 1));
    assign clr_last = (r_clr_addr == AW'(MEM_DEPTH - 1));

    // one closure step: fold in epsilon targets of the current state
    assign clos_add    = r_work[r_cnt] ? (r_eps[r_cnt] & ~r_work) : '0;
    assign work_next   = r_work | clos_add;
    assign clos_change = r_changed || (|clos_add);

    // edge read data belongs to the state addressed in the previous cycle
    assign step_take = ((r_state == S_STEP && r_cnt != '0) || r_state == S_STEP_LAST)
                       && r_active[r_step_idx];
    assign best_take = r_active[r_cnt] && (r_acc[r_cnt] > r_best);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        CMD_ADD_EDGE: n_state = (from_ok && to_ok) ? S_EDGE_RD : S_SCAN;
                        CMD_START:    n_state = S_CLOS;
                        CMD_FEED:     n_state = S_STEP;
                        default:      n_state = S_SCAN;
                    endcase
                end
            end
            S_EDGE_RD:   n_state = S_EDGE_WR;
            S_EDGE_WR:   n_state = S_SCAN;
            S_STEP: begin
                if (cnt_last) n_state = S_STEP_LAST;
            end
            S_STEP_LAST: n_state = S_CLOS;
            S_CLOS: begin
                if (cnt_last && !clos_change) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (cnt_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_from_idx, r_sym};
        mem_wdata = r_rd_data | to_onehot;
        mem_raddr = {r_from_idx, r_sym};
        out_load  = 1'b0;
        n_cnt     = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            S_EDGE_WR: begin
                mem_we = 1'b1;
            end
            S_STEP: begin
                mem_raddr = {r_cnt, r_sym};
                n_cnt     = cnt_last ? '0 : r_cnt + SW'(1);
            end
            S_CLOS, S_SCAN: begin
                n_cnt = cnt_last ? '0 : r_cnt + SW'(1);
            end
            S_DONE: begin
                out_load = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_cnt           <= '0;
            r_clr_addr      <= '0;
            r_changed       <= 1'b0;
            r_initial_state <= '0;
            r_active        <= NUM_STATES'(1);
            r_out_valid     <= 1'b0;
            for (int s = 0; s < NUM_STATES; s++) begin
                r_eps[s] <= '0;
                r_acc[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cfg_we) r_initial_state <= i_cfg_wdata;

            // epsilon and accept table writes happen as the load command is taken
            if (in_acc && in_cmd == CMD_ADD_EPS && from_ok && to_ok)
                r_eps[from_idx] <= r_eps[from_idx] | (NUM_STATES'(1) << to_idx);
            if (in_acc && in_cmd == CMD_SET_ACCEPT && from_ok)
                r_acc[from_idx] <= atype_val;

            // closure pass bookkeeping
            if (r_state == S_CLOS) begin
                r_changed <= cnt_last ? 1'b0 : clos_change;
                if (cnt_last && !clos_change) r_active <= work_next;
            end else begin
                r_changed <= 1'b0;
            end

            // output slot
            if (out_load)
                r_out_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_step_idx <= r_cnt;
        if (in_acc) begin
            r_from_idx <= from_idx;
            r_to_idx   <= to_idx;
            r_sym      <= sym_idx;
            r_work     <= (in_cmd == CMD_START) ? start_set : '0;
        end else if (step_take) begin
            r_work <= r_work | r_rd_data;
        end else if (r_state == S_CLOS) begin
            r_work <= work_next;
        end
        if (r_state == S_IDLE)
            r_best <= '0;
        else if (r_state == S_SCAN && best_take)
            r_best <= r_acc[r_cnt];
        if (out_load) begin
            r_out_match <= best_wide[TYPE_FLD_W-1:0];
            r_out_alive <= |r_active;
        end
    end

    assign best_wide = {TYPE_FLD_W'(0), r_best};

    // edge memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_edge_mem[mem_waddr] <= mem_wdata;
        r_rd_data <= r_edge_mem[mem_raddr];
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_alive, r_out_match};

    // checks
    `NFASM_ASSERT_NXT(a_leave_idle, i_clk, i_rst_n, in_acc, r_state != S_IDLE, "item taken but sequencer stayed idle")
    `NFASM_ASSERT_NXT(a_alive_ok, i_clk, i_rst_n, out_load, o_m_axis_tvalid && (o_m_axis_tdata[4] == (|r_active)), "alive flag does not match active set")
    `NFASM_ASSERT_IMP(a_valid_src, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(r_state) == S_DONE, "result shown outside done state")
    `NFASM_ASSERT_NXT(a_scan_hold, i_clk, i_rst_n, r_state == S_SCAN, $stable(r_active), "active set moved during scan")

endmodule
